[rtl/vad_pkg.sv]
// ----------------------------------------------------------------------------
// vad_pkg: shared types, constants and trig tables for the vector angle block
// Holds the quadrant codes, the search control word that moves down the
// pipeline, and the sine/cosine tables used by the degree search.
// ----------------------------------------------------------------------------
package vad_pkg;

  // Search range and widths
  localparam int MAX_DEG   = 89;
  localparam int DIAG_DEG  = 45;
  localparam int DEG_W     = 7;
  localparam int TAB_DEPTH = 128;
  localparam int ANGLE_W   = 9;

  // Table format: 96 fraction bits, cut into three 32-bit limbs
  localparam int TRIG_W = 96;
  localparam int LIMB_W = 32;
  localparam int N_LIMB = 3;

  // Working format for building the tables: 32 integer and 160 fraction bits
  localparam int WIDE_W = 192;
  localparam int FRAC_W = 160;

  localparam logic [WIDE_W-1:0] PI_FIX  =
    {32'h0000_0003, 160'h243F6A8885A308D313198A2E03707344A4093822};
  localparam logic [WIDE_W-1:0] ONE_FIX = {32'h0000_0001, 160'h0};

  // Quadrant base angles
  localparam logic [ANGLE_W-1:0] BASE_0   = 9'd0;
  localparam logic [ANGLE_W-1:0] BASE_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] BASE_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] BASE_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] FULL_TURN = 9'd360;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  // Control word carried with each vector through the search
  typedef struct packed {
    logic             valid;
    logic             zero;
    quad_t            quad;
    logic [DEG_W-1:0] prefix;
  } srch_ctl_t;

  typedef logic [TAB_DEPTH-1:0][TRIG_W-1:0] trig_tab_t;

  function automatic logic [ANGLE_W-1:0] quad_base(input quad_t quad);
    logic [ANGLE_W-1:0] base;
    case (quad)
      QUAD_0:   base = BASE_0;
      QUAD_90:  base = BASE_90;
      QUAD_180: base = BASE_180;
      QUAD_270: base = BASE_270;
      default:  base = BASE_0;
    endcase
    return base;
  endfunction

  // Fixed-point multiply in the working format, truncated
  function automatic logic [WIDE_W-1:0] fmul(input logic [WIDE_W-1:0] a,
                                             input logic [WIDE_W-1:0] b);
    logic [2*WIDE_W-1:0] p;
    p = {{WIDE_W{1'b0}}, a} * {{WIDE_W{1'b0}}, b};
    return p[FRAC_W +: WIDE_W];
  endfunction

  // Build sin or cos of whole degrees 1..89; entries past 89 stay zero
  function automatic trig_tab_t build_trig(input logic want_sin);
    logic [WIDE_W-1:0] x;
    logic [WIDE_W-1:0] x2;
    logic [WIDE_W-1:0] t;
    logic [WIDE_W-1:0] s1;
    logic [WIDE_W-1:0] c1;
    logic [WIDE_W-1:0] sk;
    logic [WIDE_W-1:0] ck;
    logic [WIDE_W-1:0] sn;
    logic [WIDE_W-1:0] cn;
    trig_tab_t         tab;
    tab = '0;
    x   = PI_FIX / 180;
    x2  = fmul(x, x);
    // sine of one degree by its series
    t  = x;
    s1 = x;
    t = fmul(t, x2) / 6;   s1 = s1 - t;
    t = fmul(t, x2) / 20;  s1 = s1 + t;
    t = fmul(t, x2) / 42;  s1 = s1 - t;
    t = fmul(t, x2) / 72;  s1 = s1 + t;
    t = fmul(t, x2) / 110; s1 = s1 - t;
    t = fmul(t, x2) / 156; s1 = s1 + t;
    t = fmul(t, x2) / 210; s1 = s1 - t;
    t = fmul(t, x2) / 272; s1 = s1 + t;
    // cosine of one degree by its series
    t  = ONE_FIX;
    c1 = ONE_FIX;
    t = fmul(t, x2) / 2;   c1 = c1 - t;
    t = fmul(t, x2) / 12;  c1 = c1 + t;
    t = fmul(t, x2) / 30;  c1 = c1 - t;
    t = fmul(t, x2) / 56;  c1 = c1 + t;
    t = fmul(t, x2) / 90;  c1 = c1 - t;
    t = fmul(t, x2) / 132; c1 = c1 + t;
    t = fmul(t, x2) / 182; c1 = c1 - t;
    t = fmul(t, x2) / 240; c1 = c1 + t;
    // rotate one degree at a time
    sk = '0;
    ck = ONE_FIX;
    for (int k = 1; k <= MAX_DEG; k++) begin
      cn = fmul(ck, c1) - fmul(sk, s1);
      sn = fmul(sk, c1) + fmul(ck, s1);
      ck = cn;
      sk = sn;
      tab[k] = want_sin ? sk[FRAC_W-1 -: TRIG_W] : ck[FRAC_W-1 -: TRIG_W];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b1);
  localparam trig_tab_t COS_TAB = build_trig(1'b0);

endpackage

[rtl/vad_step.sv]
// ----------------------------------------------------------------------------
// vad_step: one bit of the binary degree search
// Tries prefix plus one bit as the next degree k and keeps it when
// a*cos(k) >= b*sin(k) (a >= b at 45, never past 89). Four register stages:
// table lookup, limb products, product sums, compare and prefix update.
// ----------------------------------------------------------------------------
module vad_step
  import vad_pkg::*;
#(
  parameter int BIT = 6,
  parameter int CW  = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  srch_ctl_t       ctl_i,
  input  logic [CW-1:0]   a_i,
  input  logic [CW-1:0]   b_i,
  output srch_ctl_t       ctl_o,
  output logic [CW-1:0]   a_o,
  output logic [CW-1:0]   b_o
);

  localparam int PW = CW + LIMB_W;
  localparam int SW = CW + TRIG_W;

  // Stage 1: candidate degree and its constants
  srch_ctl_t         ctl1;
  logic [CW-1:0]     a1, b1;
  logic [DEG_W-1:0]  cand1, cand_next;
  logic [TRIG_W-1:0] cos1, sin1;

  assign cand_next = ctl_i.prefix | (DEG_W'(1) << BIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (adv) begin
      ctl1  <= ctl_i;
      a1    <= a_i;
      b1    <= b_i;
      cand1 <= cand_next;
      cos1  <= COS_TAB[cand_next];
      sin1  <= SIN_TAB[cand_next];
    end
  end

  // Stage 2: limb products
  srch_ctl_t        ctl2;
  logic [CW-1:0]    a2, b2;
  logic [DEG_W-1:0] cand2;
  logic             ge2;
  logic [PW-1:0]    pc2 [N_LIMB];
  logic [PW-1:0]    ps2 [N_LIMB];
  logic [PW-1:0]    pc_next [N_LIMB];
  logic [PW-1:0]    ps_next [N_LIMB];

  always_comb begin
    for (int i = 0; i < N_LIMB; i++) begin
      pc_next[i] = PW'(a1) * PW'(cos1[LIMB_W*i +: LIMB_W]);
      ps_next[i] = PW'(b1) * PW'(sin1[LIMB_W*i +: LIMB_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else if (adv) begin
      ctl2  <= ctl1;
      a2    <= a1;
      b2    <= b1;
      cand2 <= cand1;
      ge2   <= (a1 >= b1);
      pc2   <= pc_next;
      ps2   <= ps_next;
    end
  end

  // Stage 3: sum the shifted limb products
  srch_ctl_t        ctl3;
  logic [CW-1:0]    a3, b3;
  logic [DEG_W-1:0] cand3;
  logic             ge3;
  logic [SW-1:0]    sum_c3, sum_s3;
  logic [SW-1:0]    sum_c_next, sum_s_next;

  always_comb begin
    sum_c_next = '0;
    sum_s_next = '0;
    for (int i = 0; i < N_LIMB; i++) begin
      sum_c_next = sum_c_next + (SW'(pc2[i]) << (LIMB_W * i));
      sum_s_next = sum_s_next + (SW'(ps2[i]) << (LIMB_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else if (adv) begin
      ctl3   <= ctl2;
      a3     <= a2;
      b3     <= b2;
      cand3  <= cand2;
      ge3    <= ge2;
      sum_c3 <= sum_c_next;
      sum_s3 <= sum_s_next;
    end
  end

  // Stage 4: compare and keep the candidate on a hit
  logic      hit;
  srch_ctl_t ctl_next;

  always_comb begin
    if (cand3 > DEG_W'(MAX_DEG)) begin
      hit = 1'b0;
    end else if (cand3 == DEG_W'(DIAG_DEG)) begin
      hit = ge3;
    end else begin
      hit = (sum_c3 >= sum_s3);
    end
    ctl_next = ctl3;
    if (hit) begin
      ctl_next.prefix = cand3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else if (adv) begin
      ctl_o <= ctl_next;
      a_o   <= a3;
      b_o   <= b3;
    end
  end

  // Hold everything while the pipeline is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ctl_o) && $stable(a_o) && $stable(b_o))
    else $error("search stage changed during a stall");

  // A candidate beyond the table range never replaces the prefix
  a_range: assert property (@(posedge clk) disable iff (rst)
    adv && ctl3.valid && cand3 > DEG_W'(MAX_DEG) |=> ctl_o.prefix == $past(ctl3.prefix))
    else $error("out-of-range degree accepted");

  // Valid bits move one stage per advance
  a_valid: assert property (@(posedge clk) disable iff (rst)
    adv |=> ctl_o.valid == $past(ctl3.valid))
    else $error("valid bit lost or invented in search stage");

endmodule

[rtl/vector_angle_degrees.sv]
// ----------------------------------------------------------------------------
// vector_angle_degrees: direction of a signed 2-D vector in whole degrees
// Returns floor of atan2(-y, x) in degrees, 0..359, zero vector gives 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one vector per transfer, x_coord in s_tdata[31:0],
//   y_coord in s_tdata[63:32]; the low COORD_WIDTH bits of each are taken
//   and read as signed.
//   Output channel m_*: one angle per input, in order, m_tdata[8:0].
//   Throughput: one vector per cycle while the output is not stalled. Results
//   pass through thirty register stages, the first of them loaded at the
//   input transfer: one sorting stage, seven search steps of four
//   stages each (table lookup, 32x32 limb products, product sum, compare)
//   and the output register.
//   Reset clears all valid bits; no result is pending after reset.
//   When the receiver stalls, the output register holds its result and the
//   pipeline keeps taking vectors until a result reaches the last search
//   stage; from then on s_tready stays low until m_tready returns. Nothing
//   is dropped or repeated.
// ----------------------------------------------------------------------------
module vector_angle_degrees
  import vad_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] x_coord, [63:32] y_coord
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [8:0] angle_deg, [15:9] zero
);

  localparam int CW     = COORD_WIDTH;
  localparam int NSTEPS = DEG_W;

  logic adv;

  // Signed coordinates and their magnitudes
  logic [CW-1:0] x_c, y_c, x_mag, y_mag;
  logic          x_neg, y_neg, x_nz, y_nz;

  assign x_c   = s_tdata[CW-1:0];
  assign y_c   = s_tdata[32 +: CW];
  assign x_neg = x_c[CW-1];
  assign y_neg = y_c[CW-1];
  assign x_nz  = |x_c;
  assign y_nz  = |y_c;
  assign x_mag = x_neg ? (~x_c + CW'(1)) : x_c;
  assign y_mag = y_neg ? (~y_c + CW'(1)) : y_c;

  // Sort into a quadrant and pick the magnitudes a, b
  srch_ctl_t     ctl_in;
  logic [CW-1:0] a_in, b_in;

  always_comb begin
    ctl_in.valid  = s_tvalid;
    ctl_in.zero   = !x_nz && !y_nz;
    ctl_in.prefix = '0;
    if (!x_neg && x_nz && (y_neg || !y_nz)) begin
      ctl_in.quad = QUAD_0;
      a_in = y_mag;
      b_in = x_mag;
    end else if ((x_neg || !x_nz) && y_neg) begin
      ctl_in.quad = QUAD_90;
      a_in = x_mag;
      b_in = y_mag;
    end else if (x_neg && !y_neg) begin
      ctl_in.quad = QUAD_180;
      a_in = y_mag;
      b_in = x_mag;
    end else begin
      ctl_in.quad = QUAD_270;
      a_in = x_mag;
      b_in = y_mag;
    end
  end

  srch_ctl_t     ctl [NSTEPS+1];
  logic [CW-1:0] a   [NSTEPS+1];
  logic [CW-1:0] b   [NSTEPS+1];

  // Sorting stage register
  srch_ctl_t     ctl0;
  logic [CW-1:0] a0, b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else if (adv) begin
      ctl0 <= ctl_in;
      a0   <= a_in;
      b0   <= b_in;
    end
  end

  assign ctl[0] = ctl0;
  assign a[0]   = a0;
  assign b[0]   = b0;

  // Binary search over the degree, most significant bit first
  for (genvar s = 0; s < NSTEPS; s++) begin : g_step
    vad_step #(
      .BIT (NSTEPS - 1 - s),
      .CW  (CW)
    ) u_step (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .ctl_i (ctl[s]),
      .a_i   (a[s]),
      .b_i   (b[s]),
      .ctl_o (ctl[s+1]),
      .a_o   (a[s+1]),
      .b_o   (b[s+1])
    );
  end

  // Advance unless a finished result meets a full, stalled output register
  assign adv      = !ctl[NSTEPS].valid || !m_tvalid || m_tready;
  assign s_tready = adv;

  // Output register
  logic [ANGLE_W-1:0] angle, angle_next;

  always_comb begin
    if (ctl[NSTEPS].zero) begin
      angle_next = '0;
    end else begin
      angle_next = quad_base(ctl[NSTEPS].quad) + ANGLE_W'(ctl[NSTEPS].prefix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      if (ctl[NSTEPS].valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl[NSTEPS].valid) begin
      angle <= angle_next;
    end
  end

  assign m_tdata = {{(16 - ANGLE_W){1'b0}}, angle};

  // Angle stays below a full turn
  a_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> angle < FULL_TURN)
    else $error("angle out of range");

  // Input side blocks only behind a stalled output
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready && ctl[NSTEPS].valid)
    else $error("input stalled without output back-pressure");

  // Nothing leaves right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: stream testbench for vector_angle_degrees
// Sends signed (x, y) vectors and checks each returned angle against a
// predictor built on sine/cosine tables with 160 fraction bits. The
// stimulus covers axes, diagonals and extreme coordinates, then random
// vectors, many of them placed within two units of a whole-degree boundary.
// Both sides idle at random in several phases.
// ----------------------------------------------------------------------------
module tb
  import vad_pkg::*;
();

  localparam int          FX_FRAC   = 160;
  localparam int          N_RANDOM  = 450;
  localparam int          PHASE_LEN = 40;
  localparam int          DRAIN_AT  = 220;
  localparam int          TAIL_WAIT = 40;
  localparam int unsigned LIMIT     = 200000;
  localparam logic [31:0] C_MIN     = 32'h8000_0000;
  localparam logic [31:0] C_MAX     = 32'h7FFF_FFFF;

  typedef logic [191:0] fx_t;
  localparam fx_t FX_ONE = fx_t'(1) << FX_FRAC;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    idle_mode_t  mode;
    bit          drain;
  } vec_item_t;

  typedef struct {
    logic [31:0]        x;
    logic [31:0]        y;
    logic [ANGLE_W-1:0] angle;
  } angle_exp_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // [31:0] x_coord, [63:32] y_coord
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [8:0] angle_deg, [15:9] zero

  fx_t         sin_fix [0:MAX_DEG];
  fx_t         cos_fix [0:MAX_DEG];
  vec_item_t   pending_q[$];
  angle_exp_t  angle_q[$];
  idle_mode_t  idle_mode = IDLE_NONE;
  int unsigned n_issued  = 0;
  int unsigned n_results = 0;
  int unsigned n_bad     = 0;
  int unsigned cycles    = 0;

  vector_angle_degrees dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Fixed-point multiply, 32 integer and 160 fraction bits, truncated
  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    logic [383:0] p;
    p = {192'b0, a} * {192'b0, b};
    return p[FX_FRAC +: 192];
  endfunction

  // arctan(1/n) by its alternating series
  function automatic fx_t atan_recip(input int unsigned n);
    fx_t term;
    fx_t sum;
    term = FX_ONE / n;
    sum  = term;
    for (int k = 1; k < 200; k++) begin
      term = term / n;
      term = term / n;
      if (term == '0) break;
      if (k % 2 == 1) sum = sum - term / (2 * k + 1);
      else sum = sum + term / (2 * k + 1);
    end
    return sum;
  endfunction

  // Build sin and cos of 0..89 degrees by rotating one degree at a time
  task automatic build_trig_tables();
    fx_t pi_v;
    fx_t rad;
    fx_t rad2;
    fx_t term;
    fx_t s1;
    fx_t c1;
    pi_v = (atan_recip(5) << 4) - (atan_recip(239) << 2);
    rad  = pi_v / 180;
    rad2 = fx_mul(rad, rad);
    s1   = rad;
    term = rad;
    for (int n = 1; n < 40; n++) begin
      term = fx_mul(term, rad2) / ((2 * n) * (2 * n + 1));
      if (term == '0) break;
      if (n % 2 == 1) s1 = s1 - term;
      else s1 = s1 + term;
    end
    c1   = FX_ONE;
    term = FX_ONE;
    for (int n = 1; n < 40; n++) begin
      term = fx_mul(term, rad2) / ((2 * n - 1) * (2 * n));
      if (term == '0) break;
      if (n % 2 == 1) c1 = c1 - term;
      else c1 = c1 + term;
    end
    sin_fix[0] = '0;
    cos_fix[0] = FX_ONE;
    for (int k = 1; k <= MAX_DEG; k++) begin
      cos_fix[k] = fx_mul(cos_fix[k-1], c1) - fx_mul(sin_fix[k-1], s1);
      sin_fix[k] = fx_mul(sin_fix[k-1], c1) + fx_mul(cos_fix[k-1], s1);
    end
  endtask

  // Floor of atan2(-y, x) in degrees: quadrant base plus the largest whole
  // degree k whose tangent the magnitude ratio still reaches
  function automatic logic [ANGLE_W-1:0] floor_heading_deg(input logic signed [31:0] x,
                                                           input logic signed [31:0] y);
    logic [31:0]        a;
    logic [31:0]        b;
    logic [ANGLE_W-1:0] base;
    logic [ANGLE_W-1:0] deg;
    logic [223:0]       pa;
    logic [223:0]       pb;
    bit                 hit;
    deg = '0;
    if (x == 0 && y == 0) return BASE_0;
    if (x > 0 && y <= 0) begin
      base = BASE_0;   a = -y; b = x;
    end else if (x <= 0 && y < 0) begin
      base = BASE_90;  a = -x; b = -y;
    end else if (x < 0 && y >= 0) begin
      base = BASE_180; a = y;  b = -x;
    end else begin
      base = BASE_270; a = x;  b = y;
    end
    for (int k = 1; k <= MAX_DEG; k++) begin
      if (k == DIAG_DEG) begin
        hit = (a >= b);
      end else begin
        pa  = {192'b0, a} * {32'b0, cos_fix[k]};
        pb  = {192'b0, b} * {32'b0, sin_fix[k]};
        hit = (pa >= pb);
      end
      if (hit) deg = ANGLE_W'(k);
    end
    return base + deg;
  endfunction

  function automatic bit roll_pct(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic add_vec(input logic [31:0] x, input logic [31:0] y,
                         input idle_mode_t mode, input bit drain);
    vec_item_t item;
    item.x     = x;
    item.y     = y;
    item.mode  = mode;
    item.drain = drain;
    pending_q.push_back(item);
  endtask

  // Map in-quadrant magnitudes (a toward the next axis, b along the base axis)
  // back to a vector in quadrant q
  task automatic place_vec(input int q, input logic [31:0] a, input logic [31:0] b,
                           input idle_mode_t mode, input bit drain);
    case (q)
      0:       add_vec(b, -a, mode, drain);
      1:       add_vec(-a, -b, mode, drain);
      2:       add_vec(-b, a, mode, drain);
      default: add_vec(a, b, mode, drain);
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Present vectors from the pending queue; hold each until its transfer
  always @(posedge clk) begin : drive_vectors
    vec_item_t item;
    bit        idle;
    bit        drained;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        angle_exp_t e;
        e.x     = s_tdata[31:0];
        e.y     = s_tdata[63:32];
        e.angle = floor_heading_deg(s_tdata[31:0], s_tdata[63:32]);
        angle_q.push_back(e);
        n_issued <= n_issued + 1;
      end
      if (!s_tvalid || s_tready) begin
        drained = !(s_tvalid && s_tready) && (n_issued == n_results);
        idle    = 1'b1;
        if (pending_q.size() != 0) begin
          case (pending_q[0].mode)
            IDLE_SENDER: idle = roll_pct(58);
            IDLE_BOTH:   idle = roll_pct(6);
            default:     idle = 1'b0;
          endcase
          if (pending_q[0].drain && !drained) idle = 1'b1;
        end
        if (!idle) begin
          item = pending_q.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= {item.y, item.x};
          idle_mode <= item.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side according to the current idling phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: m_tready <= !roll_pct(58);
        IDLE_BOTH:     m_tready <= !roll_pct(6);
        default:       m_tready <= 1'b1;
      endcase
    end
  end

  // Compare each result transfer with the oldest expected angle
  always @(posedge clk) begin : check_angles
    angle_exp_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results <= n_results + 1;
      if (angle_q.size() == 0) begin
        if (n_bad < 10) $display("unexpected result: angle %0d", m_tdata[ANGLE_W-1:0]);
        n_bad++;
      end else begin
        want = angle_q.pop_front();
        if (m_tdata[ANGLE_W-1:0] !== want.angle) begin
          if (n_bad < 10)
            $display("angle mismatch: x=%0d y=%0d expected %0d got %0d",
                     $signed(want.x), $signed(want.y), want.angle, m_tdata[ANGLE_W-1:0]);
          n_bad++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int          n_directed;
    int          n_near;
    int          kind;
    int          q;
    int          k;
    idle_mode_t  mode;
    bit          drain;
    logic [31:0] a;
    logic [31:0] b;
    logic [223:0] a_wide;
    longint      a_val;
    n_near = 0;
    build_trig_tables();

    // Origin, axes, diagonals and extreme coordinates
    add_vec(32'd0, 32'd0, IDLE_NONE, 1'b0);
    add_vec(32'd1, 32'd0, IDLE_NONE, 1'b0);
    add_vec(32'd0, -32'd1, IDLE_NONE, 1'b0);
    add_vec(-32'd1, 32'd0, IDLE_NONE, 1'b0);
    add_vec(32'd0, 32'd1, IDLE_NONE, 1'b0);
    add_vec(C_MAX, 32'd0, IDLE_NONE, 1'b0);
    add_vec(C_MIN, 32'd0, IDLE_NONE, 1'b0);
    add_vec(32'd0, C_MIN, IDLE_NONE, 1'b0);
    add_vec(32'd0, C_MAX, IDLE_NONE, 1'b0);
    add_vec(32'd5, -32'd5, IDLE_NONE, 1'b0);
    add_vec(-32'd5, -32'd5, IDLE_NONE, 1'b0);
    add_vec(-32'd5, 32'd5, IDLE_NONE, 1'b0);
    add_vec(32'd5, 32'd5, IDLE_NONE, 1'b0);
    add_vec(C_MIN, C_MIN, IDLE_NONE, 1'b0);
    add_vec(C_MAX, C_MIN, IDLE_NONE, 1'b0);
    add_vec(C_MIN, C_MAX, IDLE_NONE, 1'b0);
    add_vec(C_MAX, C_MAX, IDLE_NONE, 1'b0);
    add_vec(C_MAX, C_MIN + 32'd1, IDLE_NONE, 1'b0);
    add_vec(32'd1, C_MIN, IDLE_NONE, 1'b0);
    add_vec(-32'd1, C_MIN, IDLE_NONE, 1'b0);
    add_vec(C_MAX, -32'd1, IDLE_NONE, 1'b0);
    add_vec(C_MIN, 32'd1, IDLE_NONE, 1'b0);
    add_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_NONE, 1'b0);
    n_directed = pending_q.size();

    // Random vectors; idling phase changes every PHASE_LEN items
    for (int i = 0; i < N_RANDOM; i++) begin
      mode  = idle_mode_t'((i / PHASE_LEN) % 4);
      drain = (i == 0) || (i == DRAIN_AT);
      kind  = $urandom_range(0, 9);
      q     = $urandom_range(0, 3);
      if (kind <= 2) begin
        add_vec($urandom, $urandom, mode, drain);
      end else if (kind <= 4) begin
        add_vec(32'($urandom_range(0, 32)) - 32'd16, 32'($urandom_range(0, 32)) - 32'd16,
                mode, drain);
      end else if (kind <= 7) begin
        // Land within two units of the tangent of a whole degree
        k      = $urandom_range(1, MAX_DEG);
        b      = ($urandom >> $urandom_range(1, 31)) | 32'd1;
        a_wide = ({192'b0, b} * {32'b0, sin_fix[k]}) / {32'b0, cos_fix[k]};
        a_val  = (a_wide > 224'(C_MAX)) ? longint'(C_MAX) : longint'(a_wide[31:0]);
        a_val  = a_val + $urandom_range(0, 4) - 2;
        if (a_val < 0) a_val = 0;
        if (a_val > longint'(C_MAX)) a_val = longint'(C_MAX);
        place_vec(q, a_val[31:0], b, mode, drain);
        n_near++;
      end else if (kind == 8) begin
        // Axis or exact diagonal at a random scale
        b = ($urandom >> $urandom_range(0, 31)) | 32'd1;
        if (b == C_MIN) b = C_MAX;
        a = roll_pct(50) ? b : 32'd0;
        place_vec(q, a, b, mode, drain);
      end else begin
        // One extreme coordinate against a random one
        case ($urandom_range(0, 3))
          0:       add_vec(C_MIN, $urandom, mode, drain);
          1:       add_vec(C_MAX, $urandom, mode, drain);
          2:       add_vec($urandom, C_MIN, mode, drain);
          default: add_vec($urandom, C_MAX, mode, drain);
        endcase
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every vector to be sent and every angle to come back
    while (pending_q.size() != 0 || s_tvalid || n_issued != n_results) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (angle_q.size() != 0) begin
      $display("%0d expected angles never arrived", angle_q.size());
      n_bad += angle_q.size();
    end
    $display("%0d vectors checked: %0d directed, %0d random, %0d aimed at degree boundaries",
             n_results, n_directed, N_RANDOM, n_near);
    $display("idling phases: none, sender, receiver and both; %0d mismatches", n_bad);
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
